// File: design/amd_pkg.sv
// answering machine detector: shared types, widths and codes
// no dependencies; imported by every module of the block
`default_nettype none
package amd_pkg;

	localparam int SAMPLE_W = 16;
	localparam int MAG_W    = 17;
	localparam int SUM_W    = 26;
	localparam int DUR_W    = 16;
	localparam int WC_W     = 8;
	localparam int VL_W     = 15;
	localparam int CFG_W    = 16;

	typedef enum logic [1:0] {
		DEC_NONE    = 2'd0,
		DEC_MACHINE = 2'd1,
		DEC_PERSON  = 2'd2,
		DEC_UNSURE  = 2'd3
	} dec_t;

	typedef enum logic [2:0] {
		RSN_NONE         = 3'd0,
		RSN_TOO_LONG     = 3'd1,
		RSN_MAX_INTRO    = 3'd2,
		RSN_MAX_COUNT    = 3'd3,
		RSN_SILENT_INIT  = 3'd4,
		RSN_SILENT_AFTER = 3'd5
	} rsn_t;

	typedef enum logic [1:0] {
		TALK_NONE  = 2'd0,
		TALK_START = 2'd1,
		TALK_STOP  = 2'd2
	} talk_t;

	typedef enum logic [2:0] {
		REG_VOICE_LEVEL   = 3'd0,
		REG_INITIAL_SIL   = 3'd1,
		REG_AFTER_FIRST   = 3'd2,
		REG_MAX_SESSION   = 3'd3,
		REG_INTRO_WINDOW  = 3'd4,
		REG_MIN_WORD      = 3'd5,
		REG_WORD_GAP      = 3'd6,
		REG_MAX_WORDS     = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [VL_W-1:0]  voice_level;
		logic [DUR_W-1:0] initial_silence_ms;
		logic [DUR_W-1:0] after_first_word_ms;
		logic [DUR_W-1:0] max_session_silence_ms;
		logic [DUR_W-1:0] intro_window_ms;
		logic [DUR_W-1:0] min_word_ms;
		logic [DUR_W-1:0] word_gap_ms;
		logic [WC_W-1:0]  max_words;
	} amd_cfg_t;

	localparam amd_cfg_t CFG_RESET = '{
		voice_level:            15'd256,
		initial_silence_ms:     16'd4500,
		after_first_word_ms:    16'd1000,
		max_session_silence_ms: 16'd200,
		intro_window_ms:        16'd1250,
		min_word_ms:            16'd120,
		word_gap_ms:            16'd30,
		max_words:              8'd6
	};

endpackage
`default_nettype wire

// File: design/answering_machine_detector.sv
// answering machine detector, top level: configuration registers and pipeline
// depends on amd_pkg, amd_accum, amd_classify, amd_frame
// throughput: one sample beat per cycle while sample_stall is low
// stages: input reg, frame capture, threshold product, sum compare, frame and result regs
// reset: asynchronous; registers return to their defaults, all frame state clears, no sweep
`default_nettype none
module answering_machine_detector import amd_pkg::*; #(
	parameter int FRAME_LEN_MS      = 20,
	parameter int RATE_DIV          = 1,
	parameter int ANALYSIS_LIMIT_MS = 5000,
	parameter int MAX_FRAME_SAMPLES = 1024
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [SAMPLE_W-1:0] sample,
	input  wire logic                frame_end,
	input  wire logic                sample_valid,
	output logic                     sample_stall,
	output logic [1:0]               decision,
	output logic [2:0]               decision_reason,
	output logic                     frame_voiced,
	output logic [1:0]               talk_change,
	output logic [WC_W-1:0]          word_total,
	output logic                     result_valid,
	input  wire logic                result_stall,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [CFG_W-1:0]    cfg_data
);

	localparam int CNT_W = $clog2(MAX_FRAME_SAMPLES + 1);

	amd_cfg_t         cfg_q;
	logic             frm_valid;
	logic             frm_ready;
	logic [SUM_W-1:0] frm_sum;
	logic [CNT_W-1:0] frm_q;
	logic             cls_valid;
	logic             cls_ready;
	logic             cls_voiced;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				REG_VOICE_LEVEL:  cfg_q.voice_level            <= cfg_data[VL_W-1:0];
				REG_INITIAL_SIL:  cfg_q.initial_silence_ms     <= cfg_data;
				REG_AFTER_FIRST:  cfg_q.after_first_word_ms    <= cfg_data;
				REG_MAX_SESSION:  cfg_q.max_session_silence_ms <= cfg_data;
				REG_INTRO_WINDOW: cfg_q.intro_window_ms        <= cfg_data;
				REG_MIN_WORD:     cfg_q.min_word_ms            <= cfg_data;
				REG_WORD_GAP:     cfg_q.word_gap_ms            <= cfg_data;
				REG_MAX_WORDS:    cfg_q.max_words              <= cfg_data[WC_W-1:0];
				default:          cfg_q                        <= cfg_q;
			endcase
		end
	end

	amd_accum #(
		.RATE_DIV          (RATE_DIV),
		.MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES)
	) u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample       (sample),
		.frame_end    (frame_end),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.frm_valid    (frm_valid),
		.frm_ready    (frm_ready),
		.frm_sum      (frm_sum),
		.frm_q        (frm_q)
	);

	amd_classify #(
		.MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES)
	) u_classify (
		.clk         (clk),
		.arst_n      (arst_n),
		.voice_level (cfg_q.voice_level),
		.frm_valid   (frm_valid),
		.frm_ready   (frm_ready),
		.frm_sum     (frm_sum),
		.frm_q       (frm_q),
		.cls_valid   (cls_valid),
		.cls_ready   (cls_ready),
		.cls_voiced  (cls_voiced)
	);

	amd_frame #(
		.FRAME_LEN_MS      (FRAME_LEN_MS),
		.ANALYSIS_LIMIT_MS (ANALYSIS_LIMIT_MS)
	) u_frame (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.cls_valid       (cls_valid),
		.cls_ready       (cls_ready),
		.cls_voiced      (cls_voiced),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.decision        (decision),
		.decision_reason (decision_reason),
		.frame_voiced    (frame_voiced),
		.talk_change     (talk_change),
		.word_total      (word_total)
	);

endmodule
`default_nettype wire

// File: design/amd_accum.sv
// input register and per-frame amplitude accumulator
// depends on amd_pkg; hands one frame beat (sum, quotient) to amd_classify
`default_nettype none
module amd_accum import amd_pkg::*; #(
	parameter int RATE_DIV          = 1,
	parameter int MAX_FRAME_SAMPLES = 1024,
	localparam int CNT_W = $clog2(MAX_FRAME_SAMPLES + 1)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [SAMPLE_W-1:0] sample,
	input  wire logic                frame_end,
	input  wire logic                sample_valid,
	output logic                     sample_stall,
	output logic                     frm_valid,
	input  wire logic                frm_ready,
	output logic [SUM_W-1:0]         frm_sum,
	output logic [CNT_W-1:0]         frm_q
);

	localparam int REM_W = (RATE_DIV > 1) ? $clog2(RATE_DIV) : 1;
	localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_FRAME_SAMPLES);
	localparam logic [REM_W-1:0] REM_LAST = REM_W'(RATE_DIV - 1);

	logic                v_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic                frame_end_s1;

	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] quo_q;
	logic [REM_W-1:0] rem_q;

	logic [MAG_W-1:0] mag;
	logic [SUM_W:0]   sum_wide;
	logic [SUM_W-1:0] sum_n;
	logic [CNT_W-1:0] cnt_n;
	logic [CNT_W-1:0] quo_n;
	logic [REM_W-1:0] rem_n;
	logic             acc_go;
	logic             rdy1;

	assign acc_go       = v_s1 && (!frame_end_s1 || frm_ready);
	assign rdy1         = !v_s1 || acc_go;
	assign sample_stall = !rdy1;

	always_comb begin
		mag      = sample_s1[SAMPLE_W-1] ? (MAG_W'(0) - {1'b1, sample_s1}) : {1'b0, sample_s1};
		sum_wide = {1'b0, sum_q} + (SUM_W + 1)'(mag);
		sum_n    = sum_q;
		cnt_n    = cnt_q;
		quo_n    = quo_q;
		rem_n    = rem_q;
		if (cnt_q < CNT_MAX) begin
			sum_n = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
			cnt_n = cnt_q + CNT_W'(1);
			if (rem_q == REM_LAST) begin
				rem_n = '0;
				quo_n = quo_q + CNT_W'(1);
			end else begin
				rem_n = rem_q + REM_W'(1);
			end
		end
	end

	assign frm_valid = v_s1 && frame_end_s1;
	assign frm_sum   = sum_n;
	assign frm_q     = quo_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			sum_q <= '0;
			cnt_q <= '0;
			quo_q <= '0;
			rem_q <= '0;
		end else begin
			if (rdy1)
				v_s1 <= sample_valid;
			if (acc_go) begin
				if (frame_end_s1) begin
					sum_q <= '0;
					cnt_q <= '0;
					quo_q <= '0;
					rem_q <= '0;
				end else begin
					sum_q <= sum_n;
					cnt_q <= cnt_n;
					quo_q <= quo_n;
					rem_q <= rem_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && sample_valid) begin
			sample_s1    <= sample;
			frame_end_s1 <= frame_end;
		end
	end

endmodule
`default_nettype wire

// File: design/amd_classify.sv
// voiced/silence classification: threshold product, then sum compare
// depends on amd_pkg; fed by amd_accum, feeds amd_frame
`default_nettype none
module amd_classify import amd_pkg::*; #(
	parameter int MAX_FRAME_SAMPLES = 1024,
	localparam int CNT_W = $clog2(MAX_FRAME_SAMPLES + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [VL_W-1:0]  voice_level,
	input  wire logic             frm_valid,
	output logic                  frm_ready,
	input  wire logic [SUM_W-1:0] frm_sum,
	input  wire logic [CNT_W-1:0] frm_q,
	output logic                  cls_valid,
	input  wire logic             cls_ready,
	output logic                  cls_voiced
);

	localparam int PROD_W = VL_W + CNT_W;
	localparam int CMP_W  = (PROD_W > SUM_W) ? PROD_W : SUM_W;

	logic              v_s2;
	logic [SUM_W-1:0]  sum_s2;
	logic [CNT_W-1:0]  q_s2;
	logic              v_s3;
	logic [SUM_W-1:0]  sum_s3;
	logic [PROD_W-1:0] prod_s3;
	logic              qnz_s3;
	logic              v_s4;
	logic              voiced_s4;
	logic              rdy3;
	logic              rdy4;
	logic [PROD_W-1:0] prod;

	assign rdy4      = !v_s4 || cls_ready;
	assign rdy3      = !v_s3 || rdy4;
	assign frm_ready = !v_s2 || rdy3;
	assign prod      = PROD_W'(voice_level) * PROD_W'(q_s2);

	assign cls_valid  = v_s4;
	assign cls_voiced = voiced_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (frm_ready)
				v_s2 <= frm_valid;
			if (rdy3)
				v_s3 <= v_s2;
			if (rdy4)
				v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (frm_ready && frm_valid) begin
			sum_s2 <= frm_sum;
			q_s2   <= frm_q;
		end
		if (rdy3 && v_s2) begin
			sum_s3  <= sum_s2;
			prod_s3 <= prod;
			qnz_s3  <= (q_s2 != '0);
		end
		if (rdy4 && v_s3)
			voiced_s4 <= qnz_s3 && (CMP_W'(sum_s3) >= CMP_W'(prod_s3));
	end

endmodule
`default_nettype wire

// File: design/amd_frame.sv
// per-frame timing, word counting and decision latch, with result register
// depends on amd_pkg; fed by amd_classify
`default_nettype none
module amd_frame import amd_pkg::*; #(
	parameter int FRAME_LEN_MS      = 20,
	parameter int ANALYSIS_LIMIT_MS = 5000
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire amd_cfg_t  cfg,
	input  wire logic      cls_valid,
	output logic           cls_ready,
	input  wire logic      cls_voiced,
	output logic           result_valid,
	input  wire logic      result_stall,
	output logic [1:0]     decision,
	output logic [2:0]     decision_reason,
	output logic           frame_voiced,
	output logic [1:0]     talk_change,
	output logic [WC_W-1:0] word_total
);

	localparam logic [DUR_W-1:0] STEP  = DUR_W'(FRAME_LEN_MS);
	localparam logic [DUR_W-1:0] LIMIT = DUR_W'(ANALYSIS_LIMIT_MS);

	typedef struct packed {
		logic init_sil;
		logic intro;
		logic intro_chk;
		logic after_chk;
		logic talking;
		logic brk;
		logic counted;
	} flags_t;

	function automatic logic [DUR_W-1:0] dur_add(input logic [DUR_W-1:0] a);
		logic [DUR_W:0] s;
		s = {1'b0, a} + {1'b0, STEP};
		return s[DUR_W] ? {DUR_W{1'b1}} : s[DUR_W-1:0];
	endfunction

	logic [DUR_W-1:0] elapsed_q, silence_q, word_q;
	logic [WC_W-1:0]  wc_q;
	flags_t           flags_q;
	dec_t             dec_q;
	rsn_t             rsn_q;

	logic [DUR_W-1:0] e_n, s_n, w_n;
	logic [WC_W-1:0]  wc_n;
	flags_t           f_n;
	dec_t             dec_n;
	rsn_t             rsn_n;
	logic             voiced_n;
	talk_t            chg_n;

	logic             out_ready;
	logic             go;

	assign out_ready = !result_valid || !result_stall;
	assign cls_ready = (dec_q != DEC_NONE) || out_ready;
	assign go        = cls_valid && (dec_q == DEC_NONE) && out_ready;

	always_comb begin
		f_n      = flags_q;
		s_n      = silence_q;
		w_n      = word_q;
		wc_n     = wc_q;
		dec_n    = dec_q;
		rsn_n    = rsn_q;
		voiced_n = 1'b0;
		chg_n    = TALK_NONE;
		e_n      = dur_add(elapsed_q);
		if (e_n >= LIMIT) begin
			dec_n = DEC_UNSURE;
			rsn_n = RSN_TOO_LONG;
		end else if (cls_voiced) begin
			voiced_n = 1'b1;
			if (!f_n.talking) begin
				f_n.talking = 1'b1;
				chg_n       = TALK_START;
			end
			w_n = dur_add(word_q);
			s_n = '0;
			if (f_n.init_sil) begin
				f_n.init_sil = 1'b0;
				f_n.brk      = 1'b0;
				f_n.intro    = 1'b1;
			end else if (f_n.intro) begin
				f_n.brk = 1'b0;
			end
			if (f_n.intro && e_n >= cfg.intro_window_ms) begin
				f_n.intro     = 1'b0;
				f_n.intro_chk = 1'b1;
			end
			if (w_n >= cfg.min_word_ms && !f_n.counted) begin
				if (wc_n != {WC_W{1'b1}})
					wc_n = wc_n + WC_W'(1);
				f_n.counted = 1'b1;
			end
			if (!f_n.intro_chk && wc_n == WC_W'(1) && f_n.intro &&
			    w_n >= cfg.intro_window_ms) begin
				f_n.intro_chk = 1'b1;
				dec_n         = DEC_MACHINE;
				rsn_n         = RSN_MAX_INTRO;
			end else if (wc_n >= cfg.max_words) begin
				dec_n = DEC_MACHINE;
				rsn_n = RSN_MAX_COUNT;
			end
		end else begin
			if (f_n.talking) begin
				f_n.talking = 1'b0;
				chg_n       = TALK_STOP;
			end
			s_n = dur_add(silence_q);
			if (f_n.intro && e_n >= cfg.intro_window_ms) begin
				f_n.intro     = 1'b0;
				f_n.intro_chk = 1'b1;
			end
			if (f_n.intro && s_n >= cfg.word_gap_ms)
				f_n.brk = 1'b1;
			if (s_n >= cfg.word_gap_ms) begin
				w_n         = '0;
				f_n.counted = 1'b0;
			end
			if (f_n.init_sil && s_n >= cfg.initial_silence_ms) begin
				dec_n = DEC_PERSON;
				rsn_n = RSN_SILENT_INIT;
			end else if (!f_n.after_chk && wc_n == WC_W'(1) &&
			             s_n >= cfg.after_first_word_ms) begin
				f_n.after_chk = 1'b1;
				dec_n         = DEC_PERSON;
				rsn_n         = RSN_SILENT_AFTER;
			end else if (s_n >= cfg.max_session_silence_ms && wc_n != '0) begin
				dec_n = DEC_PERSON;
				rsn_n = RSN_SILENT_AFTER;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q    <= '0;
			silence_q    <= '0;
			word_q       <= '0;
			wc_q         <= '0;
			flags_q      <= '{init_sil: 1'b1, default: 1'b0};
			dec_q        <= DEC_NONE;
			rsn_q        <= RSN_NONE;
			result_valid <= 1'b0;
		end else begin
			if (go) begin
				elapsed_q    <= e_n;
				silence_q    <= s_n;
				word_q       <= w_n;
				wc_q         <= wc_n;
				flags_q      <= f_n;
				dec_q        <= dec_n;
				rsn_q        <= rsn_n;
				result_valid <= 1'b1;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (go) begin
			decision        <= dec_n;
			decision_reason <= rsn_n;
			frame_voiced    <= voiced_n;
			talk_change     <= chg_n;
			word_total      <= wc_n;
		end
	end

endmodule
`default_nettype wire

// File: design/amd_checker.sv
// port-level checks on the detector's result channel, bound to the top level
// depends on amd_pkg and answering_machine_detector
`default_nettype none
module amd_checker import amd_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             result_valid,
	input wire logic             result_stall,
	input wire logic [1:0]       decision,
	input wire logic [2:0]       decision_reason,
	input wire logic             frame_voiced,
	input wire logic [1:0]       talk_change,
	input wire logic [WC_W-1:0]  word_total
);

	// stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(decision) &&
		$stable(decision_reason) && $stable(frame_voiced) &&
		$stable(talk_change) && $stable(word_total))
		else $error("stalled result changed");

	a_reason: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((decision == DEC_NONE) == (decision_reason == RSN_NONE)))
		else $error("decision and reason disagree");

	a_talk: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (talk_change != TALK_START || frame_voiced) &&
		(talk_change != TALK_STOP || !frame_voiced))
		else $error("talk change does not match frame class");

	a_unsure: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && decision == DEC_UNSURE |->
		decision_reason == RSN_TOO_LONG && !frame_voiced && talk_change == TALK_NONE)
		else $error("time limit beat malformed");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (decision != DEC_MACHINE || frame_voiced) &&
		(decision != DEC_PERSON || !frame_voiced))
		else $error("decision kind does not match frame class");

endmodule

bind answering_machine_detector amd_checker u_amd_checker (.*);
`default_nettype wire

// File: dv/answering_machine_detector_test.sv
// self-checking testbench for answering_machine_detector: drives sample beats and register
// writes, predicts every frame result and compares it field by field
// depends on amd_pkg and the answering_machine_detector rtl only
`timescale 1ns / 1ps
module answering_machine_detector_test import amd_pkg::*; ();

	localparam int FRAME_LEN_MS = 20;
	localparam int RATE_DIV     = 1;
	localparam int LIMIT_MS     = 5000;
	localparam int MAX_SAMPLES  = 1024;

	typedef enum {
		SHAPE_LOUD,
		SHAPE_QUIET,
		SHAPE_AT_LEVEL,
		SHAPE_BELOW_LEVEL,
		SHAPE_NOISE
	} frame_shape_t;

	typedef struct {
		dec_t       dec;
		rsn_t       rsn;
		bit         voiced;
		talk_t      talk;
		logic [7:0] words;
	} frame_result_t;

	class call_tracker;
		amd_cfg_t        regs;
		logic [25:0]     amp_sum;
		logic [10:0]     n_samples;
		logic [15:0]     elapsed;
		logic [15:0]     silence;
		logic [15:0]     word_len;
		logic [7:0]      words;
		bit              in_initial, intro_open, intro_done, after_done, talking, counted;
		dec_t            dec;
		rsn_t            rsn;
		frame_result_t   frame_results[$];
		int              errors, checked, beats, ignored;

		function new();
			regs = CFG_RESET;
			amp_sum = '0;
			n_samples = '0;
			elapsed = '0;
			silence = '0;
			word_len = '0;
			words = '0;
			in_initial = 1'b1;
			{intro_open, intro_done, after_done, talking, counted} = '0;
			dec = DEC_NONE;
			rsn = RSN_NONE;
		endfunction

		function logic [15:0] add_frame(logic [15:0] d);
			logic [16:0] s;
			s = {1'b0, d} + 17'(FRAME_LEN_MS);
			return (s > 17'hFFFF) ? 16'hFFFF : s[15:0];
		endfunction

		function void latch(dec_t d, rsn_t r);
			dec = d;
			rsn = r;
		endfunction

		function bit decided();
			return dec != DEC_NONE;
		endfunction

		function int frames_due();
			return frame_results.size();
		endfunction

		function void note_sample(logic [15:0] value, bit last);
			logic [16:0]   mag;
			logic [26:0]   acc;
			logic [10:0]   q;
			bit            voiced;
			talk_t         talk;
			frame_result_t r;
			beats++;
			if (dec != DEC_NONE) begin
				ignored++;
				return;
			end
			mag = value[15] ? 17'h10000 - {1'b0, value} : {1'b0, value};
			if (n_samples < 11'(MAX_SAMPLES)) begin
				acc = {1'b0, amp_sum} + 27'(mag);
				amp_sum = (acc > 27'h3FFFFFF) ? 26'h3FFFFFF : acc[25:0];
				n_samples++;
			end
			if (!last)
				return;
			q = n_samples / 11'(RATE_DIV);
			voiced = (q != 0) && (longint'(amp_sum) >= longint'(regs.voice_level) * longint'(q));
			amp_sum = '0;
			n_samples = '0;
			elapsed = add_frame(elapsed);
			talk = TALK_NONE;
			if (elapsed >= 16'(LIMIT_MS)) begin
				latch(DEC_UNSURE, RSN_TOO_LONG);
				voiced = 1'b0;
			end else if (voiced) begin
				if (!talking) begin
					talking = 1'b1;
					talk = TALK_START;
				end
				word_len = add_frame(word_len);
				silence = '0;
				if (in_initial) begin
					in_initial = 1'b0;
					intro_open = 1'b1;
				end
				if (intro_open && elapsed >= regs.intro_window_ms) begin
					intro_open = 1'b0;
					intro_done = 1'b1;
				end
				if (word_len >= regs.min_word_ms && !counted) begin
					if (words != 8'hFF)
						words++;
					counted = 1'b1;
				end
				if (!intro_done && words == 8'd1 && intro_open && word_len >= regs.intro_window_ms) begin
					intro_done = 1'b1;
					latch(DEC_MACHINE, RSN_MAX_INTRO);
				end else if (words >= regs.max_words) begin
					latch(DEC_MACHINE, RSN_MAX_COUNT);
				end
			end else begin
				if (talking) begin
					talking = 1'b0;
					talk = TALK_STOP;
				end
				silence = add_frame(silence);
				if (intro_open && elapsed >= regs.intro_window_ms) begin
					intro_open = 1'b0;
					intro_done = 1'b1;
				end
				if (silence >= regs.word_gap_ms) begin
					word_len = '0;
					counted = 1'b0;
				end
				if (in_initial && silence >= regs.initial_silence_ms) begin
					latch(DEC_PERSON, RSN_SILENT_INIT);
				end else if (!after_done && words == 8'd1 && silence >= regs.after_first_word_ms) begin
					after_done = 1'b1;
					latch(DEC_PERSON, RSN_SILENT_AFTER);
				end else if (silence >= regs.max_session_silence_ms && words != 0) begin
					latch(DEC_PERSON, RSN_SILENT_AFTER);
				end
			end
			r.dec = dec;
			r.rsn = rsn;
			r.voiced = voiced;
			r.talk = talk;
			r.words = words;
			frame_results.push_back(r);
		endfunction

		function void compare_field(string what, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [1:0] d, logic [2:0] r, logic v, logic [1:0] t,
				logic [7:0] w);
			frame_result_t e;
			if (frame_results.size() == 0) begin
				$display("%0t: result beat with nothing expected, decision %0d reason %0d",
					$time, d, r);
				errors++;
				return;
			end
			e = frame_results.pop_front();
			checked++;
			compare_field("decision", e.dec, d);
			compare_field("decision_reason", e.rsn, r);
			compare_field("frame_voiced", e.voiced, v);
			compare_field("talk_change", e.talk, t);
			compare_field("word_total", e.words, w);
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic [SAMPLE_W-1:0] sample;
	logic                frame_end;
	logic                sample_valid;
	logic                sample_stall;
	logic [1:0]          decision;
	logic [2:0]          decision_reason;
	logic                frame_voiced;
	logic [1:0]          talk_change;
	logic [WC_W-1:0]     word_total;
	logic                result_valid;
	logic                result_stall;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [2:0]          cfg_index;
	logic [CFG_W-1:0]    cfg_data;

	call_tracker calls = new();
	amd_cfg_t    cur_settings;
	int          tx_left, rx_left;
	bit          tx_calm, rx_calm;

	answering_machine_detector #(
		.FRAME_LEN_MS(FRAME_LEN_MS),
		.RATE_DIV(RATE_DIV),
		.ANALYSIS_LIMIT_MS(LIMIT_MS),
		.MAX_FRAME_SAMPLES(MAX_SAMPLES)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample),
		.frame_end(frame_end),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.decision(decision),
		.decision_reason(decision_reason),
		.frame_voiced(frame_voiced),
		.talk_change(talk_change),
		.word_total(word_total),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int draw_pause(inout int left, inout bit calm);
		if (left == 0) begin
			calm = ($urandom_range(3) == 0);
			left = $urandom_range(60, 20);
		end
		left--;
		return calm ? 0 : $urandom_range(9);
	endfunction

	task automatic send_sample(logic [15:0] value, bit last);
		int pause;
		pause = draw_pause(tx_left, tx_calm);
		@(negedge clk);
		if (pause > 0) begin
			sample_valid <= 1'b0;
			repeat (pause) @(negedge clk);
		end
		sample <= value;
		frame_end <= last;
		sample_valid <= 1'b1;
		do @(posedge clk); while (sample_stall !== 1'b0);
		calls.note_sample(value, last);
	endtask

	// hold the sender until every frame result is back and the pipeline is empty
	task automatic drain();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (calls.frames_due() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic load_settings(amd_cfg_t c);
		cfg_idx_t   idx;
		logic [15:0] data;
		for (int i = 0; i < 8; i++) begin
			idx = cfg_idx_t'(i);
			data = 16'($urandom);
			case (idx)
				REG_VOICE_LEVEL:  data[14:0] = c.voice_level;
				REG_INITIAL_SIL:  data = c.initial_silence_ms;
				REG_AFTER_FIRST:  data = c.after_first_word_ms;
				REG_MAX_SESSION:  data = c.max_session_silence_ms;
				REG_INTRO_WINDOW: data = c.intro_window_ms;
				REG_MIN_WORD:     data = c.min_word_ms;
				REG_WORD_GAP:     data = c.word_gap_ms;
				default:          data[7:0] = c.max_words;
			endcase
			@(negedge clk);
			cfg_index <= idx;
			cfg_data <= data;
			cfg_valid <= 1'b1;
			do @(posedge clk); while (cfg_ready !== 1'b1);
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
		calls.regs = c;
		cur_settings = c;
	endtask

	task automatic send_frame(frame_shape_t shape, int len);
		int          mag;
		int          level;
		logic [15:0] value;
		level = cur_settings.voice_level;
		for (int i = 0; i < len; i++) begin
			case (shape)
				SHAPE_LOUD:        mag = $urandom_range(32768, level);
				SHAPE_QUIET:       mag = (level == 0) ? 0 : $urandom_range(level - 1, 0);
				SHAPE_AT_LEVEL:    mag = level;
				SHAPE_BELOW_LEVEL: mag = (level == 0) ? 0 : level - 1;
				default:           mag = 0;
			endcase
			if (shape == SHAPE_NOISE)
				value = 16'($urandom);
			else
				value = (mag == 32768 || $urandom_range(1)) ? 16'(-mag) : 16'(mag);
			send_sample(value, i == len - 1);
		end
	endtask

	// runs of voiced and silent frames, so words and gaps form
	task automatic send_talk(int frames);
		frame_shape_t shape;
		int           run;
		int           pick;
		while (frames > 0 && !calls.decided()) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				shape = SHAPE_LOUD;
				run = $urandom_range(12, 1);
			end else if (pick < 85) begin
				shape = SHAPE_QUIET;
				run = $urandom_range(12, 1);
			end else begin
				shape = frame_shape_t'($urandom_range(4, 2));
				run = $urandom_range(3, 1);
			end
			for (int i = 0; i < run && frames > 0 && !calls.decided(); i++) begin
				send_frame(shape, ($urandom_range(9) == 0) ? $urandom_range(16, 5)
					: $urandom_range(4, 1));
				frames--;
			end
			if ($urandom_range(19) == 0)
				drain();
		end
	endtask

	// settings that cannot end the call before the final phase
	function automatic amd_cfg_t phase_settings(int p);
		amd_cfg_t c;
		c.voice_level = 15'($urandom_range(4000, 1));
		c.initial_silence_ms = 16'($urandom);
		c.after_first_word_ms = 16'($urandom_range(65535, 5000));
		c.max_session_silence_ms = 16'($urandom_range(65535, 5000));
		c.intro_window_ms = 16'($urandom_range(3000));
		c.min_word_ms = 16'($urandom_range(300));
		c.word_gap_ms = 16'($urandom_range(200));
		c.max_words = 8'($urandom_range(255, 200));
		case (p)
			0: begin
				c.voice_level = '0;
				c.initial_silence_ms = '0;
				c.after_first_word_ms = 16'hFFFF;
				c.max_session_silence_ms = 16'hFFFF;
				c.intro_window_ms = 16'hFFFF;
				c.min_word_ms = '0;
				c.word_gap_ms = '0;
				c.max_words = 8'hFF;
			end
			1: begin
				c.voice_level = 15'h7FFF;
				c.initial_silence_ms = 16'hFFFF;
				c.intro_window_ms = '0;
				c.min_word_ms = 16'hFFFF;
				c.word_gap_ms = 16'hFFFF;
			end
			3: c.voice_level = 15'd1;
			default: ;
		endcase
		return c;
	endfunction

	initial begin : result_sink
		int pause;
		result_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			pause = draw_pause(rx_left, rx_calm);
			if (pause > 0) begin
				result_stall <= 1'b1;
				repeat (pause) @(negedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!(result_valid === 1'b1 && result_stall === 1'b0));
			calls.check_result(decision, decision_reason, frame_voiced, talk_change, word_total);
		end
	end

	initial begin : stimulus
		amd_cfg_t closing;
		arst_n = 1'b0;
		sample = '0;
		frame_end = 1'b0;
		sample_valid = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_VOICE_LEVEL;
		cfg_data = '0;
		cur_settings = CFG_RESET;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed beats at the reset register values
		send_sample(16'h0000, 1'b1);
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'h0001, 1'b0);
		send_sample(16'h00FF, 1'b1);
		send_sample(16'hFF00, 1'b1);
		send_sample(16'h8000, 1'b0);
		send_sample(16'h7FFF, 1'b1);
		send_sample(16'h00FF, 1'b1);
		for (int i = 0; i < 6; i++)
			send_sample(i[0] ? 16'h8000 : 16'h7FFF, 1'b1);
		send_sample(16'h0000, 1'b0);
		send_sample(16'h0000, 1'b1);
		drain();

		for (int p = 0; p < 6; p++) begin
			load_settings(phase_settings(p));
			send_talk(30);
			if (p == 2) begin
				// overlong frame: the loud tail lies past the sample limit
				for (int i = 0; i < MAX_SAMPLES; i++)
					send_sample(16'(cur_settings.voice_level - 1), 1'b0);
				send_sample(16'h8000, 1'b0);
				send_sample(16'h8000, 1'b0);
				send_sample(16'h8000, 1'b1);
			end
			drain();
		end

		// either run up to the last frame before the time limit, or close the call early
		if ($urandom_range(1)) begin
			send_talk((LIMIT_MS - FRAME_LEN_MS - int'(calls.elapsed)) / FRAME_LEN_MS);
			drain();
		end
		closing = phase_settings(4);
		closing.after_first_word_ms = '0;
		closing.max_session_silence_ms = '0;
		closing.max_words = '0;
		load_settings(closing);
		send_talk(400);
		repeat (12) send_sample(16'($urandom), 1'($urandom_range(1)));
		drain();

		$display("Run covered %0d sample beats and %0d frame results, %0d beats after the decision",
			calls.beats, calls.checked, calls.ignored);
		$display("Call closed as %s, reason %s", calls.dec.name(), calls.rsn.name());
		if (calls.errors == 0 && calls.frames_due() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin : watchdog
		#(5_000_000);
		$display("%0t: timeout, %0d frame results still outstanding", $time, calls.frames_due());
		$display("Some tests failed");
		$finish;
	end

endmodule

// File: sim.f
design/amd_pkg.sv
design/amd_accum.sv
design/amd_classify.sv
design/amd_frame.sv
design/answering_machine_detector.sv
design/amd_checker.sv
dv/answering_machine_detector_test.sv
